// ===== rtl/tsp_pkg.sv =====
// Shared types, constants and microcode program of the transport stream packetizer.
`timescale 1ns / 1ps
package tsp_pkg;

  // Field widths
  localparam int PES_LEN_W  = 20;
  localparam int LEN_CMP_W  = 24;
  localparam int PCR_W      = 33;
  localparam int PID_W      = 13;
  localparam int TS_WORD_W  = 32;

  // Packet layout constants
  localparam logic [7:0] SYNC_BYTE         = 8'h47;
  localparam logic [7:0] FIRST_PAYLOAD_MAX = 8'd176;
  localparam logic [7:0] PAYLOAD_MAX       = 8'd184;
  localparam logic [7:0] PAYLOAD_ODD       = 8'd183;
  localparam logic [7:0] PAYLOAD_EVEN      = 8'd182;
  localparam logic [7:0] ADAPT_LEN_BASE    = 8'd183;
  localparam logic [7:0] AF_FLAGS_PCR      = 8'h10;
  localparam logic [6:0] PCR_EXT_BITS      = 7'h7e;
  localparam logic [7:0] STUFF_BYTE        = 8'hff;
  localparam logic [3:0] ADAPT_AND_PAYLOAD = 4'h3;
  localparam logic [3:0] PAYLOAD_ONLY      = 4'h1;
  localparam logic [12:0] PID_RESET        = 13'h0100;

  // Byte source selected by a microcode step
  typedef enum logic [3:0] {
    SRC_NONE,
    SRC_SYNC,
    SRC_PID_HI,
    SRC_PID_LO,
    SRC_CC,
    SRC_ALEN,
    SRC_AFLAGS,
    SRC_PCR0,
    SRC_PCR1,
    SRC_PCR2,
    SRC_PCR3,
    SRC_PCR4,
    SRC_PCR5,
    SRC_STUFF,
    SRC_PAYLOAD
  } byte_src_t;

  // Branch condition of a microcode step
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_NO_ADAPT,
    JMP_NOT_FIRST,
    JMP_STUFF_MORE,
    JMP_DISPATCH
  } jmp_t;

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE    = 4'd0;
  localparam step_t STEP_SYNC    = 4'd1;
  localparam step_t STEP_PID_HI  = 4'd2;
  localparam step_t STEP_PID_LO  = 4'd3;
  localparam step_t STEP_CC      = 4'd4;
  localparam step_t STEP_ALEN    = 4'd5;
  localparam step_t STEP_AFLAGS  = 4'd6;
  localparam step_t STEP_PCR0    = 4'd7;
  localparam step_t STEP_PCR1    = 4'd8;
  localparam step_t STEP_PCR2    = 4'd9;
  localparam step_t STEP_PCR3    = 4'd10;
  localparam step_t STEP_PCR4    = 4'd11;
  localparam step_t STEP_PCR5    = 4'd12;
  localparam step_t STEP_STUFF   = 4'd13;
  localparam step_t STEP_PAYLOAD = 4'd14;
  localparam step_t STEP_FLUSH   = 4'd15;

  typedef struct packed {
    byte_src_t src;
    logic      flush;
    jmp_t      jmp;
    step_t     target;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    byte_src_t src;
    logic      flush;
    logic      idle;
  } seq_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic stall;
    logic adapt;
    logic first;
    logic stuff_more;
    logic start_hdr;
    logic start_pay;
  } seq_stat_t;

  // Control store: one word per step
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    unique case (s)
      STEP_SYNC:    w = '{SRC_SYNC,    1'b0, JMP_NEXT,       STEP_IDLE};
      STEP_PID_HI:  w = '{SRC_PID_HI,  1'b0, JMP_NEXT,       STEP_IDLE};
      STEP_PID_LO:  w = '{SRC_PID_LO,  1'b0, JMP_NEXT,       STEP_IDLE};
      STEP_CC:      w = '{SRC_CC,      1'b0, JMP_NO_ADAPT,   STEP_PAYLOAD};
      STEP_ALEN:    w = '{SRC_ALEN,    1'b0, JMP_NEXT,       STEP_IDLE};
      STEP_AFLAGS:  w = '{SRC_AFLAGS,  1'b0, JMP_NOT_FIRST,  STEP_STUFF};
      STEP_PCR0:    w = '{SRC_PCR0,    1'b0, JMP_NEXT,       STEP_IDLE};
      STEP_PCR1:    w = '{SRC_PCR1,    1'b0, JMP_NEXT,       STEP_IDLE};
      STEP_PCR2:    w = '{SRC_PCR2,    1'b0, JMP_NEXT,       STEP_IDLE};
      STEP_PCR3:    w = '{SRC_PCR3,    1'b0, JMP_NEXT,       STEP_IDLE};
      STEP_PCR4:    w = '{SRC_PCR4,    1'b0, JMP_NEXT,       STEP_IDLE};
      STEP_PCR5:    w = '{SRC_PCR5,    1'b0, JMP_NEXT,       STEP_IDLE};
      STEP_STUFF:   w = '{SRC_STUFF,   1'b0, JMP_STUFF_MORE, STEP_STUFF};
      STEP_PAYLOAD: w = '{SRC_PAYLOAD, 1'b0, JMP_NEXT,       STEP_IDLE};
      STEP_FLUSH:   w = '{SRC_NONE,    1'b1, JMP_ALWAYS,     STEP_IDLE};
      default:      w = '{SRC_NONE,    1'b0, JMP_DISPATCH,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/tsp_if.sv =====
// Valid/ready channel interfaces for PES bytes in and transport words out.
`timescale 1ns / 1ps
interface tsp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pes_byte;
  logic        pes_start;
  logic [19:0] pes_length;
  logic [32:0] pcr_base;

  modport source (output valid, pes_byte, pes_start, pes_length, pcr_base, input ready);
  modport sink   (input valid, pes_byte, pes_start, pes_length, pcr_base, output ready);
endinterface

interface tsp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] ts_word;
  logic        packet_end;
  logic        last;

  modport source (output valid, ts_word, packet_end, last, input ready);
  modport sink   (input valid, ts_word, packet_end, last, output ready);
endinterface

// ===== rtl/tsp_seq.sv =====
// Microcode sequencer: step counter, control store lookup and branch logic.
`timescale 1ns / 1ps
module tsp_seq import tsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  seq_stat_t stat,
  output seq_ctrl_t ctrl
);

  step_t  step_r, step_nxt;
  ucode_t uw;

  // Control word of the current step
  always_comb begin
    uw         = ucode_rom(step_r);
    ctrl.src   = uw.src;
    ctrl.flush = uw.flush;
    ctrl.idle  = (uw.jmp == JMP_DISPATCH);
  end

  // Next step: dispatch from idle, otherwise branch unless stalled
  always_comb begin
    step_nxt = step_r;
    if (ctrl.idle) begin
      if (stat.start_hdr) step_nxt = STEP_SYNC;
      else if (stat.start_pay) step_nxt = STEP_PAYLOAD;
    end else if (!stat.stall) begin
      unique case (uw.jmp)
        JMP_NEXT:       step_nxt = step_r + 4'd1;
        JMP_ALWAYS:     step_nxt = uw.target;
        JMP_NO_ADAPT:   step_nxt = stat.adapt ? step_r + 4'd1 : uw.target;
        JMP_NOT_FIRST:  step_nxt = stat.first ? step_r + 4'd1 : uw.target;
        JMP_STUFF_MORE: step_nxt = stat.stuff_more ? uw.target : step_r + 4'd1;
        default:        step_nxt = step_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) step_r <= STEP_IDLE;
    else        step_r <= step_nxt;
  end

endmodule

// ===== rtl/tsp_datapath.sv =====
// Packetizer datapath: item dispatch, header byte mux, word packer and output register.
`timescale 1ns / 1ps
module tsp_datapath import tsp_pkg::*; #(
  parameter int unsigned MAX_PES_BYTES = 1048575
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [PID_W-1:0] cfg_wr_data,
  tsp_in_if.sink           in_chan,
  tsp_out_if.source        out_chan,
  input  seq_ctrl_t        ctrl,
  output seq_stat_t        stat
);

  localparam logic [LEN_CMP_W-1:0] MaxLen = LEN_CMP_W'(MAX_PES_BYTES);

  // Control state
  logic [PID_W-1:0]     pid_r, pid_nxt;
  logic [3:0]           cont_r, cont_nxt;
  logic [PES_LEN_W-1:0] pes_rem_r, pes_rem_nxt;
  logic [7:0]           pay_left_r, pay_left_nxt;
  logic [1:0]           fill_r, fill_nxt;
  logic                 hold_v_r, hold_v_nxt;
  logic                 out_v_r, out_v_nxt;

  // Payload state
  logic [7:0]           byte_r, byte_nxt;
  logic [PCR_W-1:0]     pcr_r, pcr_nxt;
  logic                 first_r, first_nxt;
  logic                 adapt_r, adapt_nxt;
  logic [7:0]           alen_r, alen_nxt;
  logic [7:0]           stuff_r, stuff_nxt;
  logic [23:0]          partial_r, partial_nxt;
  logic [TS_WORD_W-1:0] hold_word_r, hold_word_nxt;
  logic                 hold_end_r, hold_end_nxt;
  logic [TS_WORD_W-1:0] out_word_r, out_word_nxt;
  logic                 out_end_r, out_end_nxt;
  logic                 out_last_r, out_last_nxt;

  // Dispatch terms
  logic                 accept, new_pes, drop, hdr_need, adapt_d;
  logic [LEN_CMP_W-1:0] len_ext;
  logic [PES_LEN_W-1:0] rem_sat, rem_eff;
  logic [7:0]           pay_d, alen_d, stuff_d;

  // Byte path terms
  logic [7:0] b;
  logic       push_en, ends, completes, out_free, stall, do_push, do_flush;

  assign in_chan.ready     = ctrl.idle;
  assign out_chan.valid    = out_v_r;
  assign out_chan.ts_word  = out_word_r;
  assign out_chan.packet_end = out_end_r;
  assign out_chan.last     = out_last_r;

  // Packet sizing for the incoming byte
  always_comb begin
    accept   = in_chan.valid && ctrl.idle;
    new_pes  = (pes_rem_r == '0);
    drop     = new_pes && (!in_chan.pes_start || (in_chan.pes_length == '0));
    len_ext  = LEN_CMP_W'(in_chan.pes_length);
    rem_sat  = (len_ext > MaxLen) ? MaxLen[PES_LEN_W-1:0] : in_chan.pes_length;
    rem_eff  = new_pes ? rem_sat : pes_rem_r;
    hdr_need = new_pes || (pay_left_r == 8'd0);
    if (new_pes) begin
      pay_d = (rem_eff < PES_LEN_W'(FIRST_PAYLOAD_MAX)) ? rem_eff[7:0] : FIRST_PAYLOAD_MAX;
    end else begin
      pay_d = (rem_eff < PES_LEN_W'(PAYLOAD_MAX)) ? rem_eff[7:0] : PAYLOAD_MAX;
      if (pay_d == PAYLOAD_ODD) pay_d = PAYLOAD_EVEN;
    end
    adapt_d = new_pes || (pay_d < PAYLOAD_MAX);
    alen_d  = ADAPT_LEN_BASE - pay_d;
    // first packet: six PCR bytes come out of the stuffing budget
    stuff_d = new_pes ? (FIRST_PAYLOAD_MAX - pay_d) : (PAYLOAD_EVEN - pay_d);
  end

  // Byte selected by the current step
  always_comb begin
    unique case (ctrl.src)
      SRC_SYNC:    b = SYNC_BYTE;
      SRC_PID_HI:  b = {1'b0, first_r, 1'b0, pid_r[12:8]};
      SRC_PID_LO:  b = pid_r[7:0];
      SRC_CC:      b = {(adapt_r ? ADAPT_AND_PAYLOAD : PAYLOAD_ONLY), cont_r};
      SRC_ALEN:    b = alen_r;
      SRC_AFLAGS:  b = first_r ? AF_FLAGS_PCR : 8'h00;
      SRC_PCR0:    b = pcr_r[32:25];
      SRC_PCR1:    b = pcr_r[24:17];
      SRC_PCR2:    b = pcr_r[16:9];
      SRC_PCR3:    b = pcr_r[8:1];
      SRC_PCR4:    b = {pcr_r[0], PCR_EXT_BITS};
      SRC_PCR5:    b = 8'h00;
      SRC_STUFF:   b = STUFF_BYTE;
      SRC_PAYLOAD: b = byte_r;
      default:     b = 8'h00;
    endcase
  end

  // Push, stall and flush decisions
  always_comb begin
    push_en   = (ctrl.src != SRC_NONE) && !((ctrl.src == SRC_STUFF) && (stuff_r == 8'd0));
    ends      = (ctrl.src == SRC_PAYLOAD) && (pay_left_r == 8'd1);
    completes = push_en && (fill_r == 2'd3);
    out_free  = !out_v_r || out_chan.ready;
    stall     = hold_v_r && !out_free && (completes || ctrl.flush);
    do_push   = push_en && !stall;
    do_flush  = ctrl.flush && hold_v_r && !stall;

    stat.stall      = stall;
    stat.adapt      = adapt_r;
    stat.first      = first_r;
    stat.stuff_more = (stuff_r > 8'd1);
    stat.start_hdr  = accept && !drop && hdr_need;
    stat.start_pay  = accept && !drop && !hdr_need;
  end

  // Next-state logic
  always_comb begin
    pid_nxt       = pid_r;
    cont_nxt      = cont_r;
    pes_rem_nxt   = pes_rem_r;
    pay_left_nxt  = pay_left_r;
    fill_nxt      = fill_r;
    hold_v_nxt    = hold_v_r;
    out_v_nxt     = out_v_r;
    byte_nxt      = byte_r;
    pcr_nxt       = pcr_r;
    first_nxt     = first_r;
    adapt_nxt     = adapt_r;
    alen_nxt      = alen_r;
    stuff_nxt     = stuff_r;
    partial_nxt   = partial_r;
    hold_word_nxt = hold_word_r;
    hold_end_nxt  = hold_end_r;
    out_word_nxt  = out_word_r;
    out_end_nxt   = out_end_r;
    out_last_nxt  = out_last_r;

    if (cfg_wr_en) pid_nxt = cfg_wr_data;

    // latch an accepted byte and size its packet
    if (accept && !drop) begin
      byte_nxt = in_chan.pes_byte;
      if (new_pes) begin
        pes_rem_nxt = rem_sat;
        pcr_nxt     = in_chan.pcr_base;
        fill_nxt    = 2'd0;
      end
      if (hdr_need) begin
        first_nxt    = new_pes;
        adapt_nxt    = adapt_d;
        alen_nxt     = alen_d;
        stuff_nxt    = stuff_d;
        pay_left_nxt = pay_d;
      end
    end

    // output register drains
    if (out_v_r && out_chan.ready) out_v_nxt = 1'b0;

    // word packer
    if (do_push) begin
      if (fill_r == 2'd3) begin
        if (hold_v_r) begin
          out_word_nxt = hold_word_r;
          out_end_nxt  = hold_end_r;
          out_last_nxt = 1'b0;
          out_v_nxt    = 1'b1;
        end
        hold_word_nxt = {partial_r, b};
        hold_end_nxt  = ends;
        hold_v_nxt    = 1'b1;
        fill_nxt      = 2'd0;
      end else begin
        partial_nxt = {partial_r[15:0], b};
        fill_nxt    = fill_r + 2'd1;
      end
      case (ctrl.src)
        SRC_CC:    cont_nxt = cont_r + 4'd1;
        SRC_STUFF: stuff_nxt = stuff_r - 8'd1;
        SRC_PAYLOAD: begin
          pay_left_nxt = pay_left_r - 8'd1;
          pes_rem_nxt  = pes_rem_r - PES_LEN_W'(1);
        end
        default: ;
      endcase
    end

    // end of item: the held word is the final one
    if (do_flush) begin
      out_word_nxt = hold_word_r;
      out_end_nxt  = hold_end_r;
      out_last_nxt = 1'b1;
      out_v_nxt    = 1'b1;
      hold_v_nxt   = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pid_r      <= PID_RESET;
      cont_r     <= '0;
      pes_rem_r  <= '0;
      pay_left_r <= '0;
      fill_r     <= '0;
      hold_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      pid_r      <= pid_nxt;
      cont_r     <= cont_nxt;
      pes_rem_r  <= pes_rem_nxt;
      pay_left_r <= pay_left_nxt;
      fill_r     <= fill_nxt;
      hold_v_r   <= hold_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    pcr_r       <= pcr_nxt;
    first_r     <= first_nxt;
    adapt_r     <= adapt_nxt;
    alen_r      <= alen_nxt;
    stuff_r     <= stuff_nxt;
    partial_r   <= partial_nxt;
    hold_word_r <= hold_word_nxt;
    hold_end_r  <= hold_end_nxt;
    out_word_r  <= out_word_nxt;
    out_end_r   <= out_end_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

// ===== rtl/ts_video_packetizer.sv =====
// Top level of the transport stream packetizer: sequencer plus datapath.
//
//   channel   dir  handshake           word contents
//   in_chan   in   valid/ready         pes_byte, pes_start, pes_length, pcr_base
//   out_chan  out  valid/ready         ts_word, packet_end, last
//   cfg_*     in   cfg_wr_en strobe    cfg_wr_data = video PID
//
// A byte inside a packet goes through the accept step, the payload step and the end-of-item step.
// A byte that opens a packet first runs one header step per header byte (4 to 187 bytes),
// plus an empty stuffing step when an adaptation field carries no stuffing,
// since the microcode sequencer pushes one byte per cycle into the word packer unless stalled.
// A dropped byte is taken in the idle step and not packed. Output back-pressure holds the current step.
// Reset (rst_n low, synchronous) clears the sequencer, counters and valid flags.
`timescale 1ns / 1ps
module ts_video_packetizer import tsp_pkg::*; #(
  parameter int unsigned MAX_PES_BYTES = 1048575
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [PID_W-1:0] cfg_wr_data,
  tsp_in_if.sink           in_chan,
  tsp_out_if.source        out_chan
);

  seq_ctrl_t ctrl;
  seq_stat_t stat;

  tsp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  tsp_datapath #(
    .MAX_PES_BYTES (MAX_PES_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .ctrl        (ctrl),
    .stat        (stat)
  );

endmodule

// ===== rtl/tsp_checker.sv =====
// Port-level assertions for the packetizer and their bind to the top level.
`timescale 1ns / 1ps
module tsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic        out_end,
  input logic        out_last
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
    else $error("output word changed while stalled");

  // The word that closes a packet carries the final payload byte of its item
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end |-> out_last)
    else $error("packet end without last");

  // A word that is not the last of its item means the item is still in work
  a_busy_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken while an item is unfinished");

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind ts_video_packetizer tsp_checker u_tsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_word  (out_chan.ts_word),
  .out_end   (out_chan.packet_end),
  .out_last  (out_chan.last)
);
